/* hw/rtl/lrt_pkg.sv */
// Shared types and constants for the RTP receiver loss tracker.
package lrt_pkg;

   // Transaction kinds on the request channel
   localparam logic OP_PACKET = 1'b0;
   localparam logic OP_REPORT = 1'b1;

   // Packet qualification and sequence arithmetic
   localparam logic [15:0] MIN_PKT_LEN = 16'd12;
   localparam logic [15:0] WRAP_LIMIT  = 16'hFFF0;
   localparam logic [15:0] SEQ_MAX     = 16'hFFFF;

   // Fraction-lost divider: one quotient bit per step
   localparam int          FRAC_BITS = 8;
   localparam int          STEP_W    = $clog2(FRAC_BITS);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(FRAC_BITS - 1);
   localparam logic [7:0]  FRAC_MAX  = 8'hFF;

   // Register file: byte address 4*i, index taken from paddr[2]
   localparam int   CSR_ADDR_W       = 3;
   localparam logic REG_TRACKED_SSRC = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_HOLD
   } lrt_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic take_packet;
      logic take_report;
      logic div_step;
      logic load_out;
   } lrt_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic out_free;
   } lrt_sts_type;

endpackage

/* hw/rtl/lrt_ctrl.sv */
// Controller state machine: request handshake and fraction divider sequencing.
module lrt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_op,
   output logic                 req_ready,
   input  lrt_pkg::lrt_sts_type sts,
   output lrt_pkg::lrt_cmd_type cmd
);

   lrt_pkg::lrt_state_type state_ff, state_in;
   logic [lrt_pkg::STEP_W-1:0] step_ff, step_in;

   // State and step counter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lrt_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         lrt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            step_in   = '0;
            if (req_valid) begin
               if (req_op == lrt_pkg::OP_REPORT) begin
                  cmd.take_report = 1'b1;
                  state_in        = lrt_pkg::ST_DIVIDE;
               end else begin
                  cmd.take_packet = 1'b1;
               end
            end
         end
         lrt_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + lrt_pkg::STEP_W'(1);
            if (step_ff == lrt_pkg::STEP_LAST) begin
               state_in = lrt_pkg::ST_HOLD;
            end
         end
         lrt_pkg::ST_HOLD: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = lrt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lrt_pkg::ST_IDLE;
         end
      endcase
   end

   // A report always starts the divider
   a_report_divides: assert property (@(posedge clock) disable iff (reset)
      cmd.take_report |=> (state_ff == lrt_pkg::ST_DIVIDE && step_ff == '0))
      else $error("report transaction did not start the divider");

   // Divider runs exactly its step count, then waits for the output slot
   a_divide_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lrt_pkg::ST_DIVIDE && step_ff == lrt_pkg::STEP_LAST)
      |=> state_ff == lrt_pkg::ST_HOLD)
      else $error("divider did not finish after the last step");

   // Result is only loaded into a free output slot
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> sts.out_free)
      else $error("result loaded over a pending response");

endmodule

/* hw/rtl/lrt_datapath.sv */
// Datapath: sequence tracking state, loss counters, fraction divider and response register.
module lrt_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  lrt_pkg::lrt_cmd_type cmd,
   output lrt_pkg::lrt_sts_type sts,
   input  logic [31:0]          tracked_ssrc,
   input  logic [15:0]          req_packet_length,
   input  logic                 req_version_bit,
   input  logic [31:0]          req_packet_ssrc,
   input  logic [15:0]          req_seq_number,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_loss_fraction,
   output logic [23:0]          rsp_cumulative_lost,
   output logic [31:0]          rsp_ext_highest_seq
);

   // Tracking state
   logic        first_ff, first_in;
   logic [15:0] expected_ff, expected_in;
   logic [15:0] base_ff, base_in;
   logic [15:0] current_ff, current_in;
   logic [31:0] total_ff, total_in;
   logic [31:0] interval_ff, interval_in;
   logic [15:0] cycle_hi_ff, cycle_hi_in;   // cycle offset, upper half (lower half always 0)
   logic        armed_ff, armed_in;
   logic [31:0] ext_ff, ext_in;

   // Report snapshot and divider
   logic [15:0] span_ff, span_in;
   logic [15:0] rem_ff, rem_in;
   logic [7:0]  quot_ff, quot_in;
   logic        zero_ff, zero_in;
   logic        sat_ff, sat_in;
   logic [23:0] cum_ff, cum_in;
   logic [31:0] ext_snap_ff, ext_snap_in;

   // Response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  frac_out_ff, frac_out_in;
   logic [23:0] cum_out_ff, cum_out_in;
   logic [31:0] ext_out_ff, ext_out_in;

   // Packet classification
   logic        pkt_ok;
   logic        seq_ahead;
   logic        seq_behind;
   logic        legacy_skip;
   logic        wrap_gap;
   logic        in_order;
   logic        take_loss;
   logic [15:0] gap;
   logic [15:0] back_dist;
   logic [15:0] seq_next;
   logic [15:0] cycle_hi_new;
   logic [15:0] span_now;
   logic [16:0] rem_dbl;
   logic        rem_ge;

   assign pkt_ok      = (req_packet_length > lrt_pkg::MIN_PKT_LEN) && req_version_bit
                        && (req_packet_ssrc == tracked_ssrc);
   assign seq_ahead   = expected_ff < req_seq_number;
   assign seq_behind  = expected_ff > req_seq_number;
   assign back_dist   = expected_ff - req_seq_number;
   assign legacy_skip = (expected_ff == lrt_pkg::SEQ_MAX) && (req_seq_number == '0);
   assign wrap_gap    = seq_behind && !legacy_skip && (back_dist >= lrt_pkg::WRAP_LIMIT);
   assign in_order    = !seq_ahead && (!seq_behind || legacy_skip);
   assign take_loss   = seq_ahead || wrap_gap;
   assign gap         = req_seq_number - expected_ff;
   assign seq_next    = req_seq_number + 16'd1;
   assign span_now    = current_ff - base_ff;
   assign rem_dbl     = {rem_ff, 1'b0};
   assign rem_ge      = rem_dbl >= {1'b0, span_ff};

   // Cycle offset steps only on a backward in-order sequence while armed
   always_comb begin
      cycle_hi_new = cycle_hi_ff;
      armed_in     = armed_ff;
      if (req_seq_number >= ext_ff[15:0]) begin
         armed_in = 1'b1;
      end else if (armed_ff) begin
         cycle_hi_new = cycle_hi_ff + 16'd1;
         armed_in     = 1'b0;
      end
   end

   // Tracking and report next state
   always_comb begin
      first_in    = first_ff;
      expected_in = expected_ff;
      base_in     = base_ff;
      current_in  = current_ff;
      total_in    = total_ff;
      interval_in = interval_ff;
      cycle_hi_in = cycle_hi_ff;
      ext_in      = ext_ff;
      span_in     = span_ff;
      rem_in      = rem_ff;
      quot_in     = quot_ff;
      zero_in     = zero_ff;
      sat_in      = sat_ff;
      cum_in      = cum_ff;
      ext_snap_in = ext_snap_ff;
      if (cmd.take_packet && pkt_ok) begin
         if (first_ff) begin
            first_in    = 1'b0;
            expected_in = seq_next;
            base_in     = req_seq_number;
            current_in  = req_seq_number;
         end else if (take_loss) begin
            total_in    = total_ff + {16'd0, gap};
            interval_in = interval_ff + {16'd0, gap};
            expected_in = seq_next;
         end else if (in_order) begin
            expected_in = seq_next;
            current_in  = req_seq_number;
            cycle_hi_in = cycle_hi_new;
            ext_in      = {cycle_hi_new, req_seq_number};
         end
      end
      if (cmd.take_report) begin
         span_in     = span_now;
         zero_in     = (span_now == '0);
         sat_in      = interval_ff >= {16'd0, span_now};
         rem_in      = interval_ff[15:0];
         quot_in     = '0;
         cum_in      = total_ff[23:0];
         ext_snap_in = ext_ff;
         interval_in = '0;
         base_in     = current_ff;
      end
      // Restoring division, one quotient bit per step
      if (cmd.div_step) begin
         if (rem_ge) begin
            rem_in  = 16'(rem_dbl - {1'b0, span_ff});
            quot_in = {quot_ff[6:0], 1'b1};
         end else begin
            rem_in  = rem_dbl[15:0];
            quot_in = {quot_ff[6:0], 1'b0};
         end
      end
   end

   // Response register next state
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      frac_out_in  = frac_out_ff;
      cum_out_in   = cum_out_ff;
      ext_out_in   = ext_out_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         cum_out_in   = cum_ff;
         ext_out_in   = ext_snap_ff;
         if (zero_ff) begin
            frac_out_in = '0;
         end else if (sat_ff) begin
            frac_out_in = lrt_pkg::FRAC_MAX;
         end else begin
            frac_out_in = quot_ff;
         end
      end
   end

   // Control and statistics registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff     <= 1'b1;
         expected_ff  <= '0;
         base_ff      <= '0;
         current_ff   <= '0;
         total_ff     <= '0;
         interval_ff  <= '0;
         cycle_hi_ff  <= '0;
         armed_ff     <= 1'b0;
         ext_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         first_ff     <= first_in;
         expected_ff  <= expected_in;
         base_ff      <= base_in;
         current_ff   <= current_in;
         total_ff     <= total_in;
         interval_ff  <= interval_in;
         cycle_hi_ff  <= cycle_hi_in;
         if (cmd.take_packet && pkt_ok && !first_ff && in_order && !take_loss) begin
            armed_ff <= armed_in;
         end
         ext_ff       <= ext_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Divider and response payload registers
   always_ff @(posedge clock) begin
      span_ff     <= span_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      zero_ff     <= zero_in;
      sat_ff      <= sat_in;
      cum_ff      <= cum_in;
      ext_snap_ff <= ext_snap_in;
      frac_out_ff <= frac_out_in;
      cum_out_ff  <= cum_out_in;
      ext_out_ff  <= ext_out_in;
   end

   assign sts.out_free         = !rsp_valid_ff || rsp_ready;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_loss_fraction    = frac_out_ff;
   assign rsp_cumulative_lost  = cum_out_ff;
   assign rsp_ext_highest_seq  = ext_out_ff;

   // Partial remainder stays below the divisor while dividing
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_step && !zero_ff && !sat_ff) |-> rem_ff < span_ff)
      else $error("divider remainder out of range");

   // A loaded result is presented on the next cycle
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff)
      else $error("loaded result not presented");

   // A report starts a fresh loss interval
   a_interval_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.take_report |=> (interval_ff == '0 && base_ff == $past(current_ff)))
      else $error("report did not start a new interval");

endmodule

/* hw/rtl/rtp_receiver_loss_tracker.sv */
// Top level: register port, controller and datapath of the RTP receiver loss tracker.
//
// Usage:
//   Request channel (req_*): one transaction per RTP header (req_op = packet) or per
//   report request (req_op = report). Packets from the SSRC in the tracked_ssrc
//   register with length over 12 bytes and the version bit set update sequence and
//   loss tracking; all others are dropped.
//   Response channel (rsp_*): one transaction per report, carrying fraction lost,
//   24-bit cumulative loss and the extended highest sequence number.
//   Register port: tracked_ssrc at byte address 0; pready is always high.
// Timing:
//   Packets are accepted back to back.
//   A report passes through acceptance, 8 steps of the bit-serial
//   fraction divider (one quotient bit per step), and a load of the response
//   register once the output slot is free. The response is valid on the following cycle.
//   No request is accepted while the divider runs or waits for the output slot.
// Reset: synchronous, active high; clears all statistics and the register, and the
//   first qualifying packet after reset sets the sequence base.
// Stall: a pending response holds in its register; a following packet is still taken,
//   and a second report waits after its divide until the first response is taken.
module rtp_receiver_loss_tracker (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_op,
   input  logic [15:0]                     req_packet_length,
   input  logic                            req_version_bit,
   input  logic [31:0]                     req_packet_ssrc,
   input  logic [15:0]                     req_seq_number,
   // Response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_loss_fraction,
   output logic [23:0]                     rsp_cumulative_lost,
   output logic [31:0]                     rsp_ext_highest_seq,
   // Register port
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [lrt_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);

   logic [31:0]          tracked_ssrc_ff, tracked_ssrc_in;
   logic                 reg_hit;
   lrt_pkg::lrt_cmd_type cmd;
   lrt_pkg::lrt_sts_type sts;

   // Register decode
   assign reg_hit = (paddr[2] == lrt_pkg::REG_TRACKED_SSRC);
   assign pready  = 1'b1;

   always_comb begin
      tracked_ssrc_in = tracked_ssrc_ff;
      if (psel && penable && pwrite && reg_hit) begin
         tracked_ssrc_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tracked_ssrc_ff <= '0;
      end else begin
         tracked_ssrc_ff <= tracked_ssrc_in;
      end
   end

   // Read back (low address bits ignored)
   assign prdata = reg_hit ? tracked_ssrc_ff : 32'd0;

   lrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lrt_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .tracked_ssrc        (tracked_ssrc_ff),
      .req_packet_length   (req_packet_length),
      .req_version_bit     (req_version_bit),
      .req_packet_ssrc     (req_packet_ssrc),
      .req_seq_number      (req_seq_number),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_loss_fraction   (rsp_loss_fraction),
      .rsp_cumulative_lost (rsp_cumulative_lost),
      .rsp_ext_highest_seq (rsp_ext_highest_seq)
   );

endmodule

/* sim/rtp_receiver_loss_tracker_tb.sv */
// Self-checking testbench for the RTP receiver loss tracker.
module rtp_receiver_loss_tracker_tb;

   localparam int SETTLE_CYCLES  = 12;    // report divide plus response load, with margin
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_ITEMS   = 1800;
   localparam int PHASES         = 6;
   localparam int IDLE_PCT       = 36;

   typedef struct {
      logic [7:0]  loss_fraction;
      logic [23:0] cumulative_lost;
      logic [31:0] ext_highest_seq;
   } loss_report_type;

   // Loss statistics predictor and the queue of reports it still owes
   class loss_scoreboard;
      bit [31:0]       tracked_ssrc;
      bit              first_pending;
      bit [15:0]       expected_seq;
      bit [15:0]       base_seq;
      bit [15:0]       current_seq;
      bit [31:0]       total_lost;
      bit [31:0]       interval_lost;
      bit [31:0]       cycle_offset;
      bit [31:0]       extended_seq;
      bit              cycle_armed;
      loss_report_type reports_due[$];
      int unsigned     failures;
      int unsigned     reports_seen;
      int unsigned     packets_taken;
      int unsigned     offset_wraps;

      function new();
         first_pending = 1'b1;
      endfunction

      function void set_ssrc(bit [31:0] value);
         tracked_ssrc = value;
      endfunction

      // Gap ahead or across the wrap: count the skipped numbers
      function void add_loss(bit [15:0] seq);
         bit [15:0] gap;
         gap = seq - expected_seq;
         total_lost += 32'(gap);
         interval_lost += 32'(gap);
         expected_seq = seq + 16'd1;
      endfunction

      // In-order packet: track highest and extended sequence
      function void advance(bit [15:0] seq);
         expected_seq = seq + 16'd1;
         current_seq = seq;
         if (seq >= extended_seq[15:0]) begin
            cycle_armed = 1'b1;
         end else if (cycle_armed) begin
            cycle_offset += 32'h0001_0000;
            cycle_armed = 1'b0;
            offset_wraps++;
         end
         extended_seq = cycle_offset + 32'(seq);
      endfunction

      function void take_packet(bit [15:0] seq);
         bit [15:0] behind;
         behind = expected_seq - seq;
         packets_taken++;
         if (first_pending) begin
            first_pending = 1'b0;
            expected_seq = seq + 16'd1;
            base_seq = seq;
            current_seq = seq;
         end else if (seq > expected_seq) begin
            add_loss(seq);
         end else if (seq == expected_seq) begin
            advance(seq);
         end else if (expected_seq == lrt_pkg::SEQ_MAX && seq == 16'd0) begin
            advance(seq);    // legacy skip over 0xffff
         end else if (behind >= lrt_pkg::WRAP_LIMIT) begin
            add_loss(seq);
         end
         // anything else is a late packet and leaves the state alone
      endfunction

      function void build_report();
         loss_report_type rpt;
         bit [15:0]       span;
         bit [39:0]       ratio;
         span = current_seq - base_seq;
         ratio = 40'd0;
         if (span != 16'd0) begin
            ratio = {interval_lost, 8'd0} / 40'(span);
            if (ratio > 40'(lrt_pkg::FRAC_MAX)) ratio = 40'(lrt_pkg::FRAC_MAX);
         end
         rpt.loss_fraction = ratio[7:0];
         rpt.cumulative_lost = total_lost[23:0];
         rpt.ext_highest_seq = extended_seq;
         reports_due.push_back(rpt);
         interval_lost = 32'd0;
         base_seq = current_seq;
      endfunction

      // Returns 1 when the transaction touches the statistics
      function bit note_request(logic op, logic [15:0] len, logic ver,
                                logic [31:0] ssrc, logic [15:0] seq);
         if (op == lrt_pkg::OP_REPORT) begin
            build_report();
            return 1'b1;
         end
         if (len > lrt_pkg::MIN_PKT_LEN && ver && ssrc == tracked_ssrc) begin
            take_packet(seq);
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function void check_report(logic [7:0] frac, logic [23:0] cum, logic [31:0] ext);
         loss_report_type want;
         if (reports_due.size() == 0) begin
            failures++;
            $display("%0t: unexpected report, expected none, actual frac %0d cum %0d ext %h",
                     $time, frac, cum, ext);
            return;
         end
         want = reports_due.pop_front();
         reports_seen++;
         if (frac !== want.loss_fraction) begin
            failures++;
            $display("%0t: loss fraction expected %0d actual %0d",
                     $time, want.loss_fraction, frac);
         end
         if (cum !== want.cumulative_lost) begin
            failures++;
            $display("%0t: cumulative_lost expected %0d actual %0d",
                     $time, want.cumulative_lost, cum);
         end
         if (ext !== want.ext_highest_seq) begin
            failures++;
            $display("%0t: ext_highest_seq expected %h actual %h",
                     $time, want.ext_highest_seq, ext);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_op = lrt_pkg::OP_PACKET;
   logic [15:0] req_packet_length = 16'd0;
   logic        req_version_bit = 1'b0;
   logic [31:0] req_packet_ssrc = 32'd0;
   logic [15:0] req_seq_number = 16'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_loss_fraction;
   logic [23:0] rsp_cumulative_lost;
   logic [31:0] rsp_ext_highest_seq;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [lrt_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   loss_scoreboard sb;
   bit          calm = 1'b0;     // no idling on either side while set
   int unsigned sent = 0;
   int unsigned counted = 0;
   int unsigned ssrc_settings = 0;
   int unsigned idle_cycles = 0;

   rtp_receiver_loss_tracker dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_packet_length   (req_packet_length),
      .req_version_bit     (req_version_bit),
      .req_packet_ssrc     (req_packet_ssrc),
      .req_seq_number      (req_seq_number),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_loss_fraction   (rsp_loss_fraction),
      .rsp_cumulative_lost (rsp_cumulative_lost),
      .rsp_ext_highest_seq (rsp_ext_highest_seq),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Report sink: random backpressure, check every accepted report
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_report(rsp_loss_fraction, rsp_cumulative_lost, rsp_ext_highest_seq);
      end
   end

   // Watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired", $time);
         $display("Verification failed");
         $finish;
      end
   end

   // One request transaction, with optional idle cycles ahead of it
   task automatic send_item(logic op, logic [15:0] len, logic ver,
                            logic [31:0] ssrc, logic [15:0] seq);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_packet_length <= len;
      req_version_bit <= ver;
      req_packet_ssrc <= ssrc;
      req_seq_number <= seq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
      if (sb.note_request(op, len, ver, ssrc, seq)) counted++;
   endtask

   task automatic send_packet(logic [15:0] seq);
      send_item(lrt_pkg::OP_PACKET, 16'($urandom_range(13, 1500)), 1'b1,
                sb.tracked_ssrc, seq);
   endtask

   // Packet fields carry junk on a report; the block must ignore them
   task automatic send_report();
      send_item(lrt_pkg::OP_REPORT, 16'($urandom), 1'($urandom), $urandom, 16'($urandom));
   endtask

   // Let all owed reports drain and the divider settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.reports_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write: setup cycle then access cycle, then read back
   task automatic write_ssrc(logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {lrt_pkg::REG_TRACKED_SSRC, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== value) begin
         sb.failures++;
         $display("%0t: tracked_ssrc read back expected %h actual %h", $time, value, prdata);
      end
      psel <= 1'b0;
      penable <= 1'b0;
      sb.set_ssrc(value);
      ssrc_settings++;
   endtask

   // Mostly well-formed streams steered by the predicted next number,
   // with gaps, late packets, runs to the wrap and some noise
   task automatic random_item();
      int unsigned pick;
      bit [15:0]   nxt;
      pick = $urandom_range(99);
      nxt = sb.expected_seq;
      if (pick < 6) begin
         send_report();
      end else if (pick < 60) begin
         if (nxt == lrt_pkg::SEQ_MAX && $urandom_range(1) == 1) send_packet(16'd0);
         else send_packet(nxt);
      end else if (pick < 68) begin
         send_packet(nxt + 16'($urandom_range(1, 20)));
      end else if (pick < 72) begin
         send_packet(nxt - 16'($urandom_range(1, 40)));
      end else if (pick < 77) begin
         send_packet(lrt_pkg::SEQ_MAX - 16'($urandom_range(0, 24)));
      end else if (pick < 80) begin
         send_packet(16'($urandom));
      end else begin
         send_item(lrt_pkg::OP_PACKET,
                   ($urandom_range(1) == 1) ? 16'($urandom) : 16'($urandom_range(11, 14)),
                   1'($urandom),
                   ($urandom_range(1) == 1) ? sb.tracked_ssrc : $urandom,
                   16'($urandom));
      end
   endtask

   initial begin
      int unsigned goal;
      logic [31:0] t;
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_ssrc(32'hFFFF_FFFF);
      t = sb.tracked_ssrc;

      // Directed: qualification, first packet, gaps, late, wrap, legacy skip
      send_report();                                        // before any packet
      send_item(lrt_pkg::OP_PACKET, 16'd12, 1'b1, t, 16'd100);       // too short
      send_item(lrt_pkg::OP_PACKET, 16'd0, 1'b1, t, 16'd100);
      send_item(lrt_pkg::OP_PACKET, 16'd500, 1'b0, t, 16'd100);      // version clear
      send_item(lrt_pkg::OP_PACKET, 16'd500, 1'b1, ~t, 16'd100);     // other source
      send_item(lrt_pkg::OP_PACKET, 16'd13, 1'b1, t, 16'd100);       // first packet
      send_item(lrt_pkg::OP_PACKET, 16'hFFFF, 1'b1, t, 16'd101);
      send_packet(16'd105);                                 // gap ahead
      send_packet(16'd103);                                 // late
      send_packet(16'd106);
      send_report();
      send_report();                                        // zero span
      send_packet(16'hFFFD);
      send_packet(16'hFFFE);
      send_packet(16'h0000);                                // legacy skip
      send_packet(16'd1);
      send_packet(16'hFFF9);
      send_packet(16'd3);                                   // gap across wrap
      send_packet(16'd4);
      send_report();                                        // saturated fraction
      send_packet(16'hFFFF);
      send_packet(16'h0000);
      send_report();

      // Random phases, each behind a drain and a new tracked source
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         case (phase)
            0:       write_ssrc(32'h0000_0000);
            2:       write_ssrc(32'hFFFF_FFFF);
            default: write_ssrc($urandom);
         endcase
         calm = (phase == 2);
         goal = sent + RANDOM_ITEMS / PHASES;
         while (sent < goal) random_item();
      end
      calm = 1'b0;
      wait_idle();

      $display("Covered %0d request transactions (%0d touching the statistics): %0d tracked",
               sent, counted, sb.packets_taken);
      $display("packets, %0d reports checked, %0d SSRC settings, %0d sequence cycle steps.",
               sb.reports_seen, ssrc_settings, sb.offset_wraps);
      if (sb.failures == 0 && sb.reports_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/lrt_pkg.sv
hw/rtl/lrt_ctrl.sv
hw/rtl/lrt_datapath.sv
hw/rtl/rtp_receiver_loss_tracker.sv
sim/rtp_receiver_loss_tracker_tb.sv
